FILE: rtl/rlac_pkg.sv
// Shared types and constants for the RGBA layer alpha compositor.
// No dependencies; every other source file of the block but rlac_checker refers to this package.
package rlac_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned PIX_W    = 4 * CH_W;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = PIX_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_B = CFG_IDX_W'(1);

  // Result kinds.
  localparam logic KIND_PAINT   = 1'b0;
  localparam logic KIND_DISPLAY = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_LAYER = 2'd1,
    CMD_PAINT = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_FINISH = 1'b1
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // take the input item and form the first blend stage
    logic commit;  // form the result, update the accumulator, fill the output
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit;    // the item in flight produces a result
  } dp_sts_t;

endpackage

FILE: rtl/rlac_in_if.sv
// Input channel of the compositor: valid/ready handshake and one pixel item.
// Depends on rlac_pkg for the field widths.
interface rlac_in_if;
  logic                         valid;
  logic                         ready;
  logic [rlac_pkg::CMD_W-1:0]   cmd;
  logic [rlac_pkg::CH_W-1:0]    in_ch0;
  logic [rlac_pkg::CH_W-1:0]    in_ch1;
  logic [rlac_pkg::CH_W-1:0]    in_ch2;
  logic [rlac_pkg::CH_W-1:0]    in_alpha;
  logic                         brush_pick;
  logic                         layer_visible;
  logic                         last_layer;

  modport source (
    output valid, cmd, in_ch0, in_ch1, in_ch2, in_alpha, brush_pick, layer_visible,
           last_layer,
    input  ready
  );
  modport sink (
    input  valid, cmd, in_ch0, in_ch1, in_ch2, in_alpha, brush_pick, layer_visible,
           last_layer,
    output ready
  );
endinterface

FILE: rtl/rlac_out_if.sv
// Result channel of the compositor: valid/ready handshake and one pixel result.
// Depends on rlac_pkg for the field widths.
interface rlac_out_if;
  logic                      valid;
  logic                      ready;
  logic                      out_kind;
  logic [rlac_pkg::CH_W-1:0] out_ch0;
  logic [rlac_pkg::CH_W-1:0] out_ch1;
  logic [rlac_pkg::CH_W-1:0] out_ch2;
  logic [rlac_pkg::CH_W-1:0] out_alpha;

  modport source (
    output valid, out_kind, out_ch0, out_ch1, out_ch2, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_ch0, out_ch1, out_ch2, out_alpha,
    output ready
  );
endinterface

FILE: rtl/rlac_ctrl.sv
// Controller of the compositor: sequences each item through the idle and finish
// states and owns the output valid flag. Depends on rlac_pkg.
module rlac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rlac_pkg::dp_sts_t sts,
  output rlac_pkg::dp_cmd_t cmd
);

  rlac_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             can_commit;

  // The result may only be written once the output register is free or is
  // being emptied by a transfer in this cycle.
  assign can_commit = !sts.emit || !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlac_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rlac_pkg::ST_FINISH;
      end
      rlac_pkg::ST_FINISH: begin
        if (can_commit) state_nxt = rlac_pkg::ST_IDLE;
      end
      default: state_nxt = rlac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      rlac_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rlac_pkg::ST_FINISH: begin
        cmd.commit = can_commit;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit && sts.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlac_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/rlac_dp.sv
// Datapath of the compositor: brush registers, accumulator, the two blend
// stages and the output register. Depends on rlac_pkg.
module rlac_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rlac_pkg::dp_cmd_t                 cmd,
  output rlac_pkg::dp_sts_t                 sts,
  input  logic                              cfg_we,
  input  logic [rlac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlac_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [rlac_pkg::CMD_W-1:0]        in_cmd,
  input  logic [rlac_pkg::CH_W-1:0]         in_ch0,
  input  logic [rlac_pkg::CH_W-1:0]         in_ch1,
  input  logic [rlac_pkg::CH_W-1:0]         in_ch2,
  input  logic [rlac_pkg::CH_W-1:0]         in_alpha,
  input  logic                              in_brush_pick,
  input  logic                              in_layer_visible,
  input  logic                              in_last_layer,
  output logic                              out_kind,
  output logic [rlac_pkg::CH_W-1:0]         out_ch0,
  output logic [rlac_pkg::CH_W-1:0]         out_ch1,
  output logic [rlac_pkg::CH_W-1:0]         out_ch2,
  output logic [rlac_pkg::CH_W-1:0]         out_alpha
);

  localparam int unsigned W = rlac_pkg::CH_W;

  // ((s - d) * w) / 255, truncated toward zero. The unsigned quotient of a
  // magnitude up to 255*255 is exact as (m + 1 + (m >> 8)) >> 8.
  function automatic logic signed [W+1:0] mix_term(input logic [W-1:0] s,
                                                   input logic [W-1:0] d,
                                                   input logic [W-1:0] w);
    logic signed [W:0]     diff;
    logic signed [2*W+1:0] prod;
    logic [2*W:0]          mag;
    logic [2*W:0]          quo;
    logic signed [W+1:0]   qs;
    diff = $signed({1'b0, s}) - $signed({1'b0, d});
    prod = diff * $signed({1'b0, w});
    mag  = prod[2*W+1] ? (2*W+1)'(-prod) : prod[2*W:0];
    quo  = (mag + (2*W+1)'(1) + (mag >> W)) >> W;
    qs   = $signed({2'b00, quo[W-1:0]});
    mix_term = prod[2*W+1] ? -qs : qs;
  endfunction

  logic [rlac_pkg::PIX_W-1:0] brush_a_r, brush_b_r, acc_r;
  logic [rlac_pkg::PIX_W-1:0] brush;

  // Stage one operands
  logic [W-1:0] src [3];
  logic [W-1:0] dst [3];
  logic [W-1:0] src_a, dst_a;

  // Stage one registers
  logic [W-1:0]               s1_src_r [3];
  logic [W-1:0]               s1_q_r [3];
  logic [W-1:0]               s1_sa_r;
  logic [W-1:0]               s1_alpha_r;
  rlac_pkg::cmd_t             s1_cmd_r;
  logic                       s1_bad_r;
  logic                       s1_vis_r;
  logic                       s1_last_r;
  logic [rlac_pkg::PIX_W-1:0] s1_pix_r;

  logic [W-1:0]               res_ch [3];
  logic [rlac_pkg::PIX_W-1:0] blended;
  logic [rlac_pkg::PIX_W-1:0] acc_nxt;
  logic [rlac_pkg::PIX_W-1:0] res_pix;
  logic                       res_kind;
  logic                       emit;

  logic                       out_kind_r;
  logic [rlac_pkg::PIX_W-1:0] out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brush_a_r <= '0;
      brush_b_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rlac_pkg::CFG_BRUSH_A) brush_a_r <= cfg_wdata;
      if (cfg_index == rlac_pkg::CFG_BRUSH_B) brush_b_r <= cfg_wdata;
    end
  end

  assign brush = in_brush_pick ? brush_b_r : brush_a_r;

  // Paint blends the brush over the pixel; a layer blends the pixel over the
  // accumulator. Brush bytes run in the opposite order to the channels.
  always_comb begin
    if (in_cmd == rlac_pkg::CMD_PAINT) begin
      src[0] = brush[3*W-1:2*W];
      src[1] = brush[2*W-1:W];
      src[2] = brush[W-1:0];
      src_a  = brush[4*W-1:3*W];
      dst[0] = in_ch0;
      dst[1] = in_ch1;
      dst[2] = in_ch2;
      dst_a  = in_alpha;
    end else begin
      src[0] = in_ch0;
      src[1] = in_ch1;
      src[2] = in_ch2;
      src_a  = in_alpha;
      dst[0] = acc_r[W-1:0];
      dst[1] = acc_r[2*W-1:W];
      dst[2] = acc_r[3*W-1:2*W];
      dst_a  = acc_r[4*W-1:3*W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        s1_src_r[i] <= src[i];
        s1_q_r[i]   <= W'($signed({2'b00, src[i]}) - mix_term(src[i], dst[i], dst_a));
      end
      s1_sa_r    <= src_a;
      s1_alpha_r <= W'($signed({2'b00, dst_a}) + mix_term({W{1'b1}}, dst_a, src_a));
      s1_cmd_r   <= rlac_pkg::cmd_t'(in_cmd);
      s1_bad_r   <= (in_cmd != rlac_pkg::CMD_LOAD) && (in_cmd != rlac_pkg::CMD_LAYER)
                    && (in_cmd != rlac_pkg::CMD_PAINT);
      s1_vis_r   <= in_layer_visible;
      s1_last_r  <= in_last_layer;
      s1_pix_r   <= {in_alpha, in_ch2, in_ch1, in_ch0};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_ch[i] = W'($signed({2'b00, s1_q_r[i]}) + mix_term(s1_src_r[i], s1_q_r[i], s1_sa_r));
    end
  end

  assign blended = {s1_alpha_r, res_ch[2], res_ch[1], res_ch[0]};

  always_comb begin
    acc_nxt  = acc_r;
    res_pix  = blended;
    res_kind = rlac_pkg::KIND_DISPLAY;
    emit     = 1'b0;
    if (!s1_bad_r) begin
      unique case (s1_cmd_r)
        rlac_pkg::CMD_PAINT: begin
          res_kind = rlac_pkg::KIND_PAINT;
          emit     = 1'b1;
        end
        rlac_pkg::CMD_LOAD: begin
          acc_nxt = s1_pix_r;
          res_pix = s1_pix_r;
          emit    = s1_last_r;
        end
        rlac_pkg::CMD_LAYER: begin
          if (s1_vis_r) acc_nxt = blended;
          res_pix = s1_vis_r ? blended : acc_r;
          emit    = s1_last_r;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  assign sts.emit = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.commit) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && emit) begin
      out_kind_r <= res_kind;
      out_pix_r  <= res_pix;
    end
  end

  assign out_kind  = out_kind_r;
  assign out_ch0   = out_pix_r[W-1:0];
  assign out_ch1   = out_pix_r[2*W-1:W];
  assign out_ch2   = out_pix_r[3*W-1:2*W];
  assign out_alpha = out_pix_r[4*W-1:3*W];

endmodule

FILE: rtl/rgba_layer_alpha_compositor.sv
// RGBA layer alpha compositor: each item passes the idle and the finish state. In
// the cycle of its transfer the first blend stage (q per channel, and the new alpha) is
// formed and registered; in the finish state the second blend stage gives the
// result, the accumulator is updated and the result enters the output register.
// The finish state waits only while the output register still holds a result
// that has not been transferred. Depends on rlac_pkg, rlac_in_if, rlac_out_if,
// rlac_ctrl and rlac_dp.
module rgba_layer_alpha_compositor (
  input  logic                           clk,
  input  logic                           rst_n,
  rlac_in_if.sink                        in_px,
  rlac_out_if.source                     out_px,
  input  logic                           cfg_we,
  input  logic [rlac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlac_pkg::CFG_W-1:0]     cfg_wdata
);

  rlac_pkg::dp_cmd_t dp_cmd;
  rlac_pkg::dp_sts_t dp_sts;

  rlac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .in_ready  (in_px.ready),
    .out_valid (out_px.valid),
    .out_ready (out_px.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  rlac_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .sts              (dp_sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_px.cmd),
    .in_ch0           (in_px.in_ch0),
    .in_ch1           (in_px.in_ch1),
    .in_ch2           (in_px.in_ch2),
    .in_alpha         (in_px.in_alpha),
    .in_brush_pick    (in_px.brush_pick),
    .in_layer_visible (in_px.layer_visible),
    .in_last_layer    (in_px.last_layer),
    .out_kind         (out_px.out_kind),
    .out_ch0          (out_px.out_ch0),
    .out_ch1          (out_px.out_ch1),
    .out_ch2          (out_px.out_ch2),
    .out_alpha        (out_px.out_alpha)
  );

endmodule

FILE: rtl/rlac_checker.sv
// Port-level checks for the compositor and the bind that attaches them.
// Depends on rgba_layer_alpha_compositor and its channel interfaces.
module rlac_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A result stays offered until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // One item at a time: the input closes for the cycle after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A fresh result follows an input transfer, with only the finish state between them.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input transfer");

  // The input reopens at once when the output side is free.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 !out_valid |=> in_ready)
    else $error("input held closed with a free output");

endmodule

bind rgba_layer_alpha_compositor rlac_checker u_rlac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_px.valid),
  .in_ready  (in_px.ready),
  .out_valid (out_px.valid),
  .out_ready (out_px.ready)
);

FILE: dv/testbench.sv
// Self-checking testbench for rgba_layer_alpha_compositor: directed and random pixel
// streams, with brush settings changed between phases and both handshakes throttled.
// Depends on rlac_pkg, rlac_in_if, rlac_out_if and the compositor RTL.
module testbench;

  localparam logic [rlac_pkg::CMD_W-1:0]     CMD_UNUSED    = 2'd3;
  localparam logic [rlac_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO  = 2'd2;
  localparam logic [rlac_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI  = 2'd3;
  localparam int                             ITEMS_PHASE   = 110;
  localparam int                             RANDOM_PHASES = 5;
  localparam int                             DRAIN_CYCLES  = 8;
  localparam int                             CYCLE_LIMIT   = 200000;
  localparam int                             FULL_SCALE    = 255;

  typedef struct packed {
    logic [rlac_pkg::CH_W-1:0] ch0;
    logic [rlac_pkg::CH_W-1:0] ch1;
    logic [rlac_pkg::CH_W-1:0] ch2;
    logic [rlac_pkg::CH_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [rlac_pkg::CMD_W-1:0] cmd;
    logic [rlac_pkg::CH_W-1:0]  ch0;
    logic [rlac_pkg::CH_W-1:0]  ch1;
    logic [rlac_pkg::CH_W-1:0]  ch2;
    logic [rlac_pkg::CH_W-1:0]  alpha;
    logic                       pick;
    logic                       visible;
    logic                       last;
  } px_item_t;

  typedef struct packed {
    logic  kind;
    rgba_t px;
  } px_result_t;

  // Tracks brush colours and the layer stack, and holds the pixels still owed.
  class compositor_scoreboard;
    logic [rlac_pkg::CFG_W-1:0] brush_a;
    logic [rlac_pkg::CFG_W-1:0] brush_b;
    rgba_t                      accum;
    px_result_t                 expected_pixels[$];
    int                         mismatches;
    int                         checked;

    function new();
      brush_a     = '0;
      brush_b     = '0;
      accum       = '0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void set_brushes(logic [rlac_pkg::CFG_W-1:0] a, logic [rlac_pkg::CFG_W-1:0] b);
      brush_a = a;
      brush_b = b;
    endfunction

    function logic [rlac_pkg::CH_W-1:0] mix_chan(logic [rlac_pkg::CH_W-1:0] s,
                                                 logic [rlac_pkg::CH_W-1:0] d,
                                                 logic [rlac_pkg::CH_W-1:0] da,
                                                 logic [rlac_pkg::CH_W-1:0] sa);
      int si, di, dai, sai, q, r;
      si  = s;
      di  = d;
      dai = da;
      sai = sa;
      q = si - ((si - di) * dai) / FULL_SCALE;
      r = q + ((si - q) * sai) / FULL_SCALE;
      return r[rlac_pkg::CH_W-1:0];
    endfunction

    function logic [rlac_pkg::CH_W-1:0] mix_alpha(logic [rlac_pkg::CH_W-1:0] da,
                                                  logic [rlac_pkg::CH_W-1:0] sa);
      int d, s, r;
      d = da;
      s = sa;
      r = d + ((FULL_SCALE - d) * s) / FULL_SCALE;
      return r[rlac_pkg::CH_W-1:0];
    endfunction

    function rgba_t blend_over(rgba_t src, rgba_t dst);
      rgba_t r;
      r.ch0   = mix_chan(src.ch0, dst.ch0, dst.alpha, src.alpha);
      r.ch1   = mix_chan(src.ch1, dst.ch1, dst.alpha, src.alpha);
      r.ch2   = mix_chan(src.ch2, dst.ch2, dst.alpha, src.alpha);
      r.alpha = mix_alpha(dst.alpha, src.alpha);
      return r;
    endfunction

    function void note_pixel(px_item_t it);
      rgba_t                      pix;
      rgba_t                      src;
      logic [rlac_pkg::CFG_W-1:0] col;
      logic                       show_acc;
      pix      = '{it.ch0, it.ch1, it.ch2, it.alpha};
      show_acc = 1'b0;
      case (it.cmd)
        rlac_pkg::CMD_PAINT: begin
          col = it.pick ? brush_b : brush_a;
          // Brush bytes are stored with channel 0 in byte 2.
          src = '{col[23:16], col[15:8], col[7:0], col[31:24]};
          expected_pixels.push_back(
            px_result_t'({rlac_pkg::KIND_PAINT, blend_over(src, pix)}));
        end
        rlac_pkg::CMD_LOAD: begin
          accum    = pix;
          show_acc = it.last;
        end
        rlac_pkg::CMD_LAYER: begin
          if (it.visible) accum = blend_over(pix, accum);
          show_acc = it.last;
        end
        default: ;
      endcase
      if (show_acc)
        expected_pixels.push_back(px_result_t'({rlac_pkg::KIND_DISPLAY, accum}));
    endfunction

    function void check_pixel(px_result_t got);
      px_result_t want;
      checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d ch %h %h %h alpha %h", $time,
                 got.kind, got.px.ch0, got.px.ch1, got.px.ch2, got.px.alpha);
      end else begin
        want = expected_pixels.pop_front();
        if (got.kind !== want.kind || got.px.ch0 !== want.px.ch0 ||
            got.px.ch1 !== want.px.ch1 || got.px.ch2 !== want.px.ch2 ||
            got.px.alpha !== want.px.alpha) begin
          mismatches++;
          $display("%0t: mismatch, expected kind %0d ch %h %h %h alpha %h,",
                   $time, want.kind, want.px.ch0, want.px.ch1, want.px.ch2,
                   want.px.alpha);
          $display("%0t:           got kind %0d ch %h %h %h alpha %h",
                   $time, got.kind, got.px.ch0, got.px.ch1, got.px.ch2, got.px.alpha);
        end
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rlac_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rlac_pkg::CFG_W-1:0]     cfg_wdata;

  rlac_in_if  in_px();
  rlac_out_if out_px();

  rgba_layer_alpha_compositor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_px),
    .out_px    (out_px),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  compositor_scoreboard sb;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   items_sent;
  int                   cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, sb.pending());
      $display("FAIL rgba_layer_alpha_compositor");
      $finish;
    end
  end

  always @(negedge clk) out_px.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_px.valid && out_px.ready)
      sb.check_pixel(px_result_t'({out_px.out_kind,
                                   out_px.out_ch0, out_px.out_ch1, out_px.out_ch2,
                                   out_px.out_alpha}));
  end

  function automatic px_item_t mk_item(logic [rlac_pkg::CMD_W-1:0] cmd,
                                       logic [rlac_pkg::CH_W-1:0] c0,
                                       logic [rlac_pkg::CH_W-1:0] c1,
                                       logic [rlac_pkg::CH_W-1:0] c2,
                                       logic [rlac_pkg::CH_W-1:0] a, logic pick, logic vis,
                                       logic last);
    px_item_t it;
    it = '{cmd, c0, c1, c2, a, pick, vis, last};
    return it;
  endfunction

  // Extremes turn up far more often than a flat draw would give them.
  function automatic logic [rlac_pkg::CH_W-1:0] rand_chan();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return rlac_pkg::CH_W'($urandom_range(255));
  endfunction

  function automatic px_item_t rand_item(logic [rlac_pkg::CMD_W-1:0] cmd, logic vis,
                                         logic last);
    return mk_item(cmd, rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                   1'($urandom_range(1)), vis, last);
  endfunction

  // Called just after a falling edge; returns just after the falling edge that
  // follows the transfer, leaving valid high for the next item.
  task automatic push_pixel(px_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_px.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_px.valid         <= 1'b1;
    in_px.cmd           <= it.cmd;
    in_px.in_ch0        <= it.ch0;
    in_px.in_ch1        <= it.ch1;
    in_px.in_ch2        <= it.ch2;
    in_px.in_alpha      <= it.alpha;
    in_px.brush_pick    <= it.pick;
    in_px.layer_visible <= it.visible;
    in_px.last_layer    <= it.last;
    do @(posedge clk); while (!in_px.ready);
    sb.note_pixel(it);
    if (it.cmd != CMD_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic write_brushes(logic [rlac_pkg::CFG_W-1:0] a, logic [rlac_pkg::CFG_W-1:0] b,
                               logic [rlac_pkg::CFG_IDX_W-1:0] spare);
    cfg_we    <= 1'b1;
    cfg_index <= rlac_pkg::CFG_BRUSH_A;
    cfg_wdata <= a;
    @(negedge clk);
    cfg_index <= rlac_pkg::CFG_BRUSH_B;
    cfg_wdata <= b;
    @(negedge clk);
    // Writes to the spare indexes must leave both brushes alone.
    cfg_index <= spare;
    cfg_wdata <= $urandom();
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_brushes(a, b);
  endtask

  task automatic end_phase();
    in_px.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly whole layer stacks, with paints, stray items and ignored commands mixed in.
  task automatic run_random(int target);
    int start;
    int r;
    int layers;
    start = items_sent;
    while (items_sent - start < target) begin
      r = $urandom_range(99);
      if (r < 55) begin
        layers = $urandom_range(5);
        push_pixel(rand_item(rlac_pkg::CMD_LOAD, 1'($urandom_range(1)), layers == 0));
        for (int i = 0; i < layers; i++)
          push_pixel(rand_item(rlac_pkg::CMD_LAYER, $urandom_range(9) < 8,
                               i == layers - 1));
      end else if (r < 80) begin
        push_pixel(rand_item(rlac_pkg::CMD_PAINT, 1'($urandom_range(1)),
                             1'($urandom_range(1))));
      end else if (r < 90) begin
        push_pixel(rand_item($urandom_range(1) ? rlac_pkg::CMD_LOAD : rlac_pkg::CMD_LAYER,
                             1'($urandom_range(1)), 1'($urandom_range(1))));
      end else if (r < 95) begin
        push_pixel(rand_item(CMD_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1))));
      end else begin
        push_pixel(rand_item(rlac_pkg::CMD_LAYER, 1'b1, $urandom_range(3) == 0));
      end
    end
  endtask

  function automatic logic [rlac_pkg::CFG_W-1:0] rand_brush();
    return {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
  endfunction

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_px.valid         = 1'b0;
    in_px.cmd           = '0;
    in_px.in_ch0        = '0;
    in_px.in_ch1        = '0;
    in_px.in_ch2        = '0;
    in_px.in_alpha      = '0;
    in_px.brush_pick    = 1'b0;
    in_px.layer_visible = 1'b0;
    in_px.last_layer    = 1'b0;
    out_px.ready        = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    items_sent          = 0;
    cycle_count         = 0;
    sb                  = new();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: distinct bytes in brush A so that the channel order shows.
    write_brushes(32'h80C0_3010, 32'hFFFF_FFFF, CFG_SPARE_LO);
    push_pixel(mk_item(rlac_pkg::CMD_PAINT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    push_pixel(mk_item(rlac_pkg::CMD_PAINT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0));
    push_pixel(mk_item(rlac_pkg::CMD_PAINT, 8'h12, 8'h34, 8'h56, 8'hFF, 1'b0, 1'b1, 1'b1));
    push_pixel(mk_item(rlac_pkg::CMD_PAINT, 8'hFF, 8'h00, 8'h80, 8'h00, 1'b1, 1'b1, 1'b1));
    push_pixel(mk_item(rlac_pkg::CMD_LOAD,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
    push_pixel(mk_item(rlac_pkg::CMD_LOAD,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0));
    push_pixel(mk_item(rlac_pkg::CMD_LAYER, 8'h10, 8'h20, 8'h30, 8'h80, 1'b0, 1'b1, 1'b0));
    push_pixel(mk_item(rlac_pkg::CMD_LAYER, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1));
    push_pixel(mk_item(CMD_UNUSED, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, 1'b1, 1'b1));
    push_pixel(mk_item(rlac_pkg::CMD_LOAD,  8'h40, 8'h80, 8'hC0, 8'h00, 1'b0, 1'b0, 1'b0));
    push_pixel(mk_item(rlac_pkg::CMD_LAYER, 8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0));
    push_pixel(mk_item(rlac_pkg::CMD_LAYER, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
    push_pixel(mk_item(rlac_pkg::CMD_LAYER, 8'h77, 8'h88, 8'h99, 8'h44, 1'b0, 1'b0, 1'b1));
    push_pixel(mk_item(rlac_pkg::CMD_LAYER, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1));
    push_pixel(mk_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    push_pixel(mk_item(rlac_pkg::CMD_LOAD,  8'hFF, 8'h00, 8'h7F, 8'h80, 1'b0, 1'b0, 1'b1));
    push_pixel(mk_item(rlac_pkg::CMD_LAYER, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1));
    push_pixel(mk_item(rlac_pkg::CMD_LAYER, 8'hC8, 8'h01, 8'hFE, 8'h01, 1'b0, 1'b1, 1'b1));
    push_pixel(mk_item(rlac_pkg::CMD_PAINT, 8'h20, 8'hE0, 8'h60, 8'h80, 1'b1, 1'b0, 1'b0));
    end_phase();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_brushes(32'h0000_0000, 32'hFFFF_FFFF, CFG_SPARE_HI);
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 0;
          write_brushes(rand_brush(), rand_brush(), CFG_SPARE_LO);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 65;
          write_brushes(32'hFFFF_FFFF, 32'h0000_0000, CFG_SPARE_HI);
        end
        3: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
          write_brushes(rand_brush(), rand_brush(), CFG_SPARE_LO);
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_brushes(rand_brush(), rand_brush(), CFG_SPARE_HI);
        end
      endcase
      run_random(ITEMS_PHASE);
      end_phase();
    end

    $display("Covered %0d pixel items over %0d brush settings and four idling patterns,",
             items_sent, RANDOM_PHASES + 1);
    $display("with %0d results checked and %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS rgba_layer_alpha_compositor");
    end else begin
      $display("FAIL rgba_layer_alpha_compositor");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rlac_pkg.sv
rtl/rlac_in_if.sv
rtl/rlac_out_if.sv
rtl/rlac_ctrl.sv
rtl/rlac_dp.sv
rtl/rgba_layer_alpha_compositor.sv
rtl/rlac_checker.sv
dv/testbench.sv
